@@ rtl/max_heap_priority_queue_top_assert.svh @@
`ifndef MAX_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH

// clocked on i_clk, off while i_rst_n is low
`define MHPQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("mhpq assertion failed");

// clocked on i_clk, also checked during reset
`define MHPQ_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("mhpq assertion failed");

`endif

@@ rtl/mhpq_pkg.sv @@
package mhpq_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W       = 7;
    localparam int LIM_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int CNT_OUT_W   = 7;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    localparam logic [1:0] REQ_INSERT  = 2'd0;
    localparam logic [1:0] REQ_EXTRACT = 2'd1;
    localparam logic [1:0] REQ_PEEK    = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     result_valid;
        logic [1:0]               status;
        logic [CNT_OUT_W-1:0]     entry_count;
        logic                     is_empty;
    } t_rsp;

    typedef struct packed {
        logic                     insert;
        logic                     extract;
        logic signed [DATA_W-1:0] key;
    } t_cell_ctl;

endpackage

@@ rtl/mhpq_cell.sv @@
module mhpq_cell
    import mhpq_pkg::*;
(
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic                     i_occ,
    input  logic                     i_prev_ge,
    input  logic signed [DATA_W-1:0] i_prev_val,
    input  logic signed [DATA_W-1:0] i_next_val,
    output logic signed [DATA_W-1:0] o_val,
    output logic                     o_ge
);

    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] n_val;

    // entries kept sorted, largest in the first cell
    assign o_ge  = i_occ && (r_val >= i_ctl.key);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.insert) begin
            if (o_ge) begin
                n_val = r_val;
            end else if (i_prev_ge) begin
                n_val = i_ctl.key;
            end else begin
                n_val = i_prev_val;
            end
        end else if (i_ctl.extract) begin
            n_val = i_next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

@@ rtl/max_heap_priority_queue_top.sv @@
// A result is registered at the edge that takes its request transfer.
// One request per cycle while results are taken; every insert, extract
// and peek is carried out by the sorted cell row at that same edge.
// Reset (synchronous, active low): queue empty, capacity limit 64,
// no result pending.
module max_heap_priority_queue_top
    import mhpq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_req               i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_rsp               o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [CAP_W-1:0] r_cap;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_rsp             r_out_data;
    t_rsp             n_out_data;

    logic                     w_in_xfer;
    logic                     w_full;
    logic                     w_empty;
    logic                     w_cfg_wr;
    t_cell_ctl                w_ctl;
    logic [MAX_ENTRIES-1:0]   w_occ;
    logic [MAX_ENTRIES-1:0]   w_ge;
    logic signed [DATA_W-1:0] w_val [MAX_ENTRIES];

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_CAPACITY);
    assign prdata   = (paddr[PADDR_W-1] == REG_CAPACITY) ?
                      PDATA_W'(r_cap) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (w_cfg_wr) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_in_xfer  = i_in_valid && o_in_ready;

    assign w_full  = (LIM_W'(r_count) >= LIM_W'(r_cap)) ||
                     (r_count == CNT_W'(MAX_ENTRIES));
    assign w_empty = (r_count == '0);

    always_comb begin
        w_ctl.key     = i_in_data.value;
        w_ctl.insert  = w_in_xfer && (i_in_data.req_type == REQ_INSERT) && !w_full;
        w_ctl.extract = w_in_xfer && (i_in_data.req_type == REQ_EXTRACT) && !w_empty;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
            logic                     w_prev_ge;
            logic signed [DATA_W-1:0] w_prev_val;
            logic signed [DATA_W-1:0] w_next_val;

            assign w_occ[g] = (r_count > CNT_W'(g));

            if (g == 0) begin : g_head
                assign w_prev_ge  = 1'b1;
                assign w_prev_val = '0;
            end else begin : g_body
                assign w_prev_ge  = w_ge[g-1];
                assign w_prev_val = w_val[g-1];
            end

            if (g == MAX_ENTRIES - 1) begin : g_tail
                assign w_next_val = w_val[g];
            end else begin : g_link
                assign w_next_val = w_val[g+1];
            end

            mhpq_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_occ      (w_occ[g]),
                .i_prev_ge  (w_prev_ge),
                .i_prev_val (w_prev_val),
                .i_next_val (w_next_val),
                .o_val      (w_val[g]),
                .o_ge       (w_ge[g])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (w_ctl.insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.extract) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_comb begin
        n_out_data              = '0;
        n_out_data.entry_count  = CNT_OUT_W'(n_count);
        n_out_data.is_empty     = (n_count == '0);
        unique case (i_in_data.req_type)
            REQ_INSERT: begin
                n_out_data.status = w_full ? ST_FULL : ST_OK;
            end
            REQ_EXTRACT, REQ_PEEK: begin
                if (w_empty) begin
                    n_out_data.status = ST_EMPTY;
                end else begin
                    n_out_data.status       = ST_OK;
                    n_out_data.result_valid = 1'b1;
                    n_out_data.result_value = w_val[0];
                end
            end
            default: begin
                n_out_data.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_in_xfer) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ rtl/mhpq_chk.sv @@
`include "max_heap_priority_queue_top_assert.svh"

module mhpq_chk
    import mhpq_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input t_rsp               o_out_data
);

    // stalled transfer holds
    `MHPQ_ASSERT(a_out_hold,
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))

    // empty flag agrees with the count
    `MHPQ_ASSERT(a_empty_flag,
        o_out_valid |-> o_out_data.is_empty == (o_out_data.entry_count == '0))

    // a real maximum only comes with status ok
    `MHPQ_ASSERT(a_valid_ok,
        o_out_valid && o_out_data.result_valid |-> o_out_data.status == ST_OK)

    // a refused request leaves no maximum and no value
    `MHPQ_ASSERT(a_refused_zero,
        o_out_valid && o_out_data.status != ST_OK |->
        !o_out_data.result_valid && o_out_data.result_value == '0)

    // nothing pending means a new request is always taken
    `MHPQ_ASSERT_ALWAYS(a_idle_ready, !o_out_valid |-> o_in_ready)

endmodule

bind max_heap_priority_queue_top mhpq_chk u_mhpq_chk (.*);
